// ===== rtl/fdmd_pkg.sv =====
`timescale 1ns / 1ps
package fdmd_pkg;

  localparam logic [1:0] CFG_CUTOFF       = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD    = 2'd1;
  localparam logic [1:0] CFG_FRAME_PIXELS = 2'd2;

  localparam logic [7:0]  CUTOFF_RESET       = 8'd50;
  localparam logic [26:0] THRESHOLD_RESET    = 27'd10;
  localparam logic [19:0] FRAME_PIXELS_RESET = 20'd307200;

  localparam logic EV_BRIGHTNESS = 1'b0;
  localparam logic EV_MOVEMENT   = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QLW    = 3;

  localparam logic [26:0] VALUE_MAX = 27'h7FFFFFF;

  typedef struct packed {
    logic [7:0] diff;
    logic [7:0] mean;
    logic       frame_end;
  } pixel_entry_t;

  // truncating divide by 3 for values below 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = {10'd0, x} * 20'd683;
    return p[18:11];
  endfunction

endpackage

// ===== rtl/fdmd_ram.sv =====
`timescale 1ns / 1ps
module fdmd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 524288
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== rtl/fdmd_fifo.sv =====
`timescale 1ns / 1ps
module fdmd_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  fdmd_pkg::pixel_entry_t       push_data,
  input  logic                         pop,
  output logic                         out_valid,
  output fdmd_pkg::pixel_entry_t       out_data,
  output logic [fdmd_pkg::QLW-1:0]     level
);

  localparam int PW = $clog2(fdmd_pkg::QDEPTH);

  fdmd_pkg::pixel_entry_t slots [fdmd_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          do_pop;

  assign out_valid = (level != '0);
  assign out_data  = slots[rd_ptr];
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        level <= level + 1'b1;
      end else if (!push && do_pop) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/fdmd_front.sv =====
`timescale 1ns / 1ps
module fdmd_front #(
  parameter int MAX_PIXELS = 524288
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [23:0]              s_tdata,
  input  logic [19:0]              frame_pixels,
  input  logic [fdmd_pkg::QLW-1:0] q_level,
  output logic                     push,
  output fdmd_pkg::pixel_entry_t   push_data
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int LW = (AW + 1 > 20) ? AW + 1 : 20;

  logic          accept;
  logic [AW-1:0] idx;
  logic [AW:0]   fill;
  logic [AW:0]   count;
  logic [19:0]   fp_eff;
  logic          frame_end;

  logic          s1_valid;
  logic [23:0]   s1_pix;
  logic          s1_fresh;
  logic          s1_end;
  logic [23:0]   rdata;
  logic [23:0]   old_pix;
  logic [9:0]    dsum;
  logic [9:0]    csum;

  assign s_tready  = ({1'b0, q_level} + {{fdmd_pkg::QLW{1'b0}}, s1_valid})
                     < (fdmd_pkg::QLW + 1)'(fdmd_pkg::QDEPTH);
  assign accept    = s_tvalid && s_tready;
  assign count     = {1'b0, idx} + 1'b1;
  assign fp_eff    = (frame_pixels == '0) ? 20'd1 : frame_pixels;
  assign frame_end = (LW'(count) >= LW'(fp_eff)) || (count == (AW + 1)'(MAX_PIXELS));

  fdmd_ram #(
    .WIDTH(24),
    .DEPTH(MAX_PIXELS)
  ) u_frame_store (
    .clk  (clk),
    .we   (accept),
    .waddr(idx),
    .wdata({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
    .raddr(idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      fill     <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        idx <= frame_end ? '0 : count[AW-1:0];
        if (count > fill) begin
          fill <= count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
      s1_fresh <= ({1'b0, idx} < fill);
      s1_end   <= frame_end;
    end
  end

  function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign old_pix = s1_fresh ? rdata : 24'd0;
  assign dsum = {2'b00, absd(s1_pix[23:16], old_pix[23:16])}
              + {2'b00, absd(s1_pix[15:8], old_pix[15:8])}
              + {2'b00, absd(s1_pix[7:0], old_pix[7:0])};
  assign csum = {2'b00, s1_pix[23:16]} + {2'b00, s1_pix[15:8]} + {2'b00, s1_pix[7:0]};

  assign push                = s1_valid;
  assign push_data.diff      = fdmd_pkg::div3(dsum);
  assign push_data.mean      = fdmd_pkg::div3(csum);
  assign push_data.frame_end = s1_end;

endmodule

// ===== rtl/fdmd_back.sv =====
`timescale 1ns / 1ps
module fdmd_back #(
  parameter int MAX_PIXELS = 524288
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  fdmd_pkg::pixel_entry_t q_data,
  output logic                   q_pop,
  input  logic [7:0]             cutoff,
  input  logic [26:0]            threshold,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,
  output logic                   m_tuser,
  output logic                   m_tlast
);

  localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int DVW = (AW + 9 > 27) ? AW + 9 : 27;

  localparam logic [2:0] B_RUN = 3'd0;
  localparam logic [2:0] B_CHK = 3'd1;
  localparam logic [2:0] B_DIV = 3'd2;
  localparam logic [2:0] B_BRI = 3'd3;
  localparam logic [2:0] B_MOV = 3'd4;

  logic [2:0]   state;
  logic [27:0]  motion;
  logic [26:0]  bsum;
  logic [AW:0]  cnt;
  logic [AW:0]  div_cnt;
  logic [26:0]  rem;
  logic [2:0]   step;
  logic [7:0]   avg;
  logic [7:0]   last_avg;

  logic [28:0]  mot_add;
  logic [27:0]  motion_next;
  logic [27:0]  bsum_add;
  logic [26:0]  bsum_next;
  logic [DVW-1:0] cmp;
  logic         out_free;
  logic         motion_hit;
  logic [26:0]  motion_val;
  logic         bri_load;
  logic         mov_load;

  assign q_pop    = (state == B_RUN) && q_valid;
  assign out_free = !m_tvalid || m_tready;

  assign mot_add     = (q_data.diff > cutoff)
                       ? {1'b0, motion} + {21'd0, q_data.diff - cutoff}
                       : {1'b0, motion};
  assign motion_next = mot_add[28] ? 28'hFFFFFFF : mot_add[27:0];
  assign bsum_add    = {1'b0, bsum} + {20'd0, q_data.mean};
  assign bsum_next   = bsum_add[27] ? fdmd_pkg::VALUE_MAX : bsum_add[26:0];

  assign cmp        = DVW'(div_cnt) << ((state == B_CHK) ? 4'd8 : {1'b0, step});
  assign motion_hit = motion >= {1'b0, threshold};
  assign motion_val = motion[27] ? fdmd_pkg::VALUE_MAX : motion[26:0];

  assign bri_load = (state == B_BRI) && (avg != last_avg) && out_free;
  assign mov_load = (state == B_MOV) && motion_hit && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_RUN;
      motion   <= '0;
      bsum     <= '0;
      cnt      <= '0;
      last_avg <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (bri_load || mov_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        B_RUN: begin
          if (q_pop) begin
            motion <= motion_next;
            bsum   <= bsum_next;
            if (q_data.frame_end) begin
              div_cnt <= cnt + 1'b1;
              rem     <= bsum_next;
              cnt     <= '0;
              state   <= B_CHK;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        B_CHK: begin
          if (DVW'(rem) >= cmp) begin
            avg   <= 8'hFF;
            state <= B_BRI;
          end else begin
            avg   <= '0;
            step  <= 3'd7;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (DVW'(rem) >= cmp) begin
            rem       <= rem - cmp[26:0];
            avg[step] <= 1'b1;
          end
          if (step == '0) begin
            state <= B_BRI;
          end
          step <= step - 1'b1;
        end
        B_BRI: begin
          if (avg == last_avg) begin
            state <= B_MOV;
          end else if (out_free) begin
            m_tuser  <= fdmd_pkg::EV_BRIGHTNESS;
            m_tdata  <= {24'd0, avg};
            m_tlast  <= !motion_hit;
            last_avg <= avg;
            state    <= B_MOV;
          end
        end
        B_MOV: begin
          if (!motion_hit || out_free) begin
            if (motion_hit) begin
              m_tuser  <= fdmd_pkg::EV_MOVEMENT;
              m_tdata  <= {5'd0, motion_val};
              m_tlast  <= 1'b1;
            end
            motion <= '0;
            bsum   <= '0;
            state  <= B_RUN;
          end
        end
        default: begin
          state <= B_RUN;
        end
      endcase
    end
  end

endmodule

// ===== rtl/frame_difference_motion_detector_core.sv =====
// A pixel is registered in the front stage, then queued until the back end pops it.
// Throughput: one pixel per cycle while the queue has room; the frame's last pixel
// then holds the back end through a saturation check and an 8-step restoring divider
// for the average plus output stalls, while a 4-entry queue holds later pixels.
// Reset: synchronous, clears control and accumulators; the frame store is not swept,
// a fill mark makes never-written pixels read as black.
`timescale 1ns / 1ps
module frame_difference_motion_detector_core #(
  parameter int MAX_PIXELS = 524288
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // event_value[26:0], zero[31:27]
  output logic        m_tuser,   // event_kind[0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [26:0] cfg_data
);

  logic [7:0]  cutoff;
  logic [26:0] threshold;
  logic [19:0] frame_pixels;

  logic                       push;
  fdmd_pkg::pixel_entry_t     push_data;
  logic                       q_pop;
  logic                       q_valid;
  fdmd_pkg::pixel_entry_t     q_data;
  logic [fdmd_pkg::QLW-1:0]   q_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff       <= fdmd_pkg::CUTOFF_RESET;
      threshold    <= fdmd_pkg::THRESHOLD_RESET;
      frame_pixels <= fdmd_pkg::FRAME_PIXELS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fdmd_pkg::CFG_CUTOFF:       cutoff       <= cfg_data[7:0];
        fdmd_pkg::CFG_THRESHOLD:    threshold    <= cfg_data;
        fdmd_pkg::CFG_FRAME_PIXELS: frame_pixels <= cfg_data[19:0];
        default: begin
        end
      endcase
    end
  end

  fdmd_front #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .frame_pixels(frame_pixels),
    .q_level     (q_level),
    .push        (push),
    .push_data   (push_data)
  );

  fdmd_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (q_pop),
    .out_valid(q_valid),
    .out_data (q_data),
    .level    (q_level)
  );

  fdmd_back #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .cutoff   (cutoff),
    .threshold(threshold),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
